// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands on i_clk, with and without reset gating
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define BPT_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/bpt_pkg.sv -----
// ---------------------------------------------------------------------------
// bpt_pkg
// request types and register indexes of the barometer compensation core
// ---------------------------------------------------------------------------
package bpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SENS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMPCO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SENS     = 3'd5;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic        [17:0] pressure_centi;
    } t_out_req;

endpackage

// ----- sv/bpt_stream_if.sv -----
// ---------------------------------------------------------------------------
// bpt_stream_if
// valid/ready request channel with a typed payload
// ---------------------------------------------------------------------------
interface bpt_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/baro_pressure_temp_compensation_core.sv -----
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation_core
// second-order pressure and temperature compensation of raw barometer data
// ---------------------------------------------------------------------------
// One request carries a raw pressure and a raw temperature conversion; one
// result carries temperature in 0.01 degC and pressure in 0.01 mbar, both
// saturated. The datapath is a nine-stage pipeline with a valid bit per
// stage: a new request is taken every cycle unless the input is refused.
// A stage holding data moves on only when the stage after it can take it,
// so the input is refused only when every stage is full. The user must
// write calibration words through the register port while no request is
// in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module baro_pressure_temp_compensation_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bpt_stream_if.sink                        i_req,
    bpt_stream_if.source                      o_res
);

    localparam int NST = 9;

    // calibration words
    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpt_pkg::CFG_SENS:          r_c1 <= i_cfg_data;
                bpt_pkg::CFG_OFFSET:        r_c2 <= i_cfg_data;
                bpt_pkg::CFG_SENS_TEMPCO:   r_c3 <= i_cfg_data;
                bpt_pkg::CFG_OFFSET_TEMPCO: r_c4 <= i_cfg_data;
                bpt_pkg::CFG_REF_TEMP:      r_c5 <= i_cfg_data;
                bpt_pkg::CFG_TEMP_SENS:     r_c6 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;
    logic [NST-1:0] n_v;

    assign adv[NST-1] = !r_v[NST-1] || o_res.ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_adv
        assign adv[k] = !r_v[k] || adv[k+1];
    end
    assign n_v = {r_v[NST-2:0], i_req.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign i_req.ready = adv[0];

    // stage 0: temperature difference
    logic        [23:0] r_s0_d1;
    logic signed [24:0] r_s0_dt;
    logic signed [24:0] n_s0_dt;

    assign n_s0_dt = $signed({1'b0, i_req.payload.raw_temperature})
                   - $signed({1'b0, r_c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s0_d1 <= i_req.payload.raw_pressure;
            r_s0_dt <= n_s0_dt;
        end
    end

    // stage 1: first-order products
    logic        [23:0] r_s1_d1;
    logic signed [41:0] r_s1_pt, r_s1_po, r_s1_ps;
    logic signed [49:0] r_s1_pdd;
    logic signed [41:0] n_s1_pt, n_s1_po, n_s1_ps;
    logic signed [49:0] n_s1_pdd;

    always_comb begin
        n_s1_pt  = r_s0_dt * $signed({1'b0, r_c6});
        n_s1_po  = r_s0_dt * $signed({1'b0, r_c4});
        n_s1_ps  = r_s0_dt * $signed({1'b0, r_c3});
        n_s1_pdd = r_s0_dt * r_s0_dt;
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_d1  <= r_s0_d1;
            r_s1_pt  <= n_s1_pt;
            r_s1_po  <= n_s1_po;
            r_s1_ps  <= n_s1_ps;
            r_s1_pdd <= n_s1_pdd;
        end
    end

    // stage 2: temperature step, offset and sensitivity
    logic        [23:0] r_s2_d1;
    logic signed [17:0] r_s2_td;
    logic signed [34:0] r_s2_off;
    logic signed [33:0] r_s2_sens;
    logic        [16:0] r_s2_t2;
    logic signed [34:0] n_s2_off;
    logic signed [33:0] n_s2_sens;

    always_comb begin
        n_s2_off  = $signed({3'b000, r_c2, 16'h0000})
                  + $signed({r_s1_po[40], r_s1_po[40:7]});
        n_s2_sens = $signed({3'b000, r_c1, 15'h0000})
                  + $signed({r_s1_ps[40], r_s1_ps[40:8]});
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s2_d1   <= r_s1_d1;
            r_s2_td   <= r_s1_pt[40:23];
            r_s2_off  <= n_s2_off;
            r_s2_sens <= n_s2_sens;
            r_s2_t2   <= r_s1_pdd[47:31];
        end
    end

    // stage 3: second-order squares
    logic        [23:0] r_s3_d1;
    logic signed [34:0] r_s3_off;
    logic signed [33:0] r_s3_sens;
    logic signed [19:0] r_s3_temp;
    logic        [34:0] r_s3_a;
    logic        [33:0] r_s3_b;
    logic               cold, deep;
    logic signed [18:0] tp;
    logic signed [35:0] sq_a;
    logic signed [37:0] sq_b;
    logic signed [19:0] n_s3_temp;
    logic        [34:0] n_s3_a;
    logic        [33:0] n_s3_b;

    always_comb begin
        cold      = r_s2_td[17];
        deep      = r_s2_td < -18'sd3500;
        tp        = $signed({r_s2_td[17], r_s2_td}) + 19'sd3500;
        sq_a      = r_s2_td * r_s2_td;
        sq_b      = tp * tp;
        n_s3_a    = cold ? sq_a[34:0] : '0;
        n_s3_b    = deep ? sq_b[33:0] : '0;
        n_s3_temp = $signed({{2{r_s2_td[17]}}, r_s2_td}) + 20'sd2000
                  - $signed({3'b000, cold ? r_s2_t2 : 17'h00000});
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s3_d1   <= r_s2_d1;
            r_s3_off  <= r_s2_off;
            r_s3_sens <= r_s2_sens;
            r_s3_temp <= n_s3_temp;
            r_s3_a    <= n_s3_a;
            r_s3_b    <= n_s3_b;
        end
    end

    // stage 4: correction terms and temperature clamp
    logic        [23:0] r_s4_d1;
    logic signed [34:0] r_s4_off;
    logic signed [33:0] r_s4_sens;
    logic signed [15:0] r_s4_temp;
    logic        [37:0] r_s4_off2;
    logic        [36:0] r_s4_sens2;
    logic        [37:0] a5, b11;
    logic        [36:0] b7;
    logic signed [15:0] n_s4_temp;
    logic        [37:0] n_s4_off2;
    logic        [36:0] n_s4_sens2;

    always_comb begin
        a5         = {3'b000, r_s3_a} + {1'b0, r_s3_a, 2'b00};
        b7         = {r_s3_b, 3'b000} - {3'b000, r_s3_b};
        b11        = {1'b0, r_s3_b, 3'b000} + {3'b000, r_s3_b, 1'b0}
                   + {4'h0, r_s3_b};
        n_s4_off2  = {1'b0, a5[37:1]} + {1'b0, b7};
        n_s4_sens2 = {1'b0, a5[37:2]} + b11[37:1];
        if (r_s3_temp < -20'sd32768) begin
            n_s4_temp = 16'sh8000;
        end else if (r_s3_temp > 20'sd32767) begin
            n_s4_temp = 16'sh7fff;
        end else begin
            n_s4_temp = r_s3_temp[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s4_d1    <= r_s3_d1;
            r_s4_off   <= r_s3_off;
            r_s4_sens  <= r_s3_sens;
            r_s4_temp  <= n_s4_temp;
            r_s4_off2  <= n_s4_off2;
            r_s4_sens2 <= n_s4_sens2;
        end
    end

    // stage 5: corrected offset and sensitivity
    logic        [23:0] r_s5_d1;
    logic signed [15:0] r_s5_temp;
    logic signed [39:0] r_s5_off;
    logic signed [38:0] r_s5_sens;
    logic signed [39:0] n_s5_off;
    logic signed [38:0] n_s5_sens;

    always_comb begin
        n_s5_off  = $signed({{5{r_s4_off[34]}}, r_s4_off})
                  - $signed({2'b00, r_s4_off2});
        n_s5_sens = $signed({{5{r_s4_sens[33]}}, r_s4_sens})
                  - $signed({2'b00, r_s4_sens2});
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s5_d1   <= r_s4_d1;
            r_s5_temp <= r_s4_temp;
            r_s5_off  <= n_s5_off;
            r_s5_sens <= n_s5_sens;
        end
    end

    // stage 6: pressure product in two halves
    logic signed [15:0] r_s6_temp;
    logic signed [39:0] r_s6_off;
    logic        [43:0] r_s6_pl;
    logic signed [43:0] r_s6_ph;
    logic        [43:0] n_s6_pl;
    logic signed [43:0] n_s6_ph;

    always_comb begin
        n_s6_pl = {20'h00000, r_s5_d1} * {24'h000000, r_s5_sens[19:0]};
        n_s6_ph = $signed({1'b0, r_s5_d1}) * $signed(r_s5_sens[38:20]);
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s6_temp <= r_s5_temp;
            r_s6_off  <= r_s5_off;
            r_s6_pl   <= n_s6_pl;
            r_s6_ph   <= n_s6_ph;
        end
    end

    // stage 7: recombine and scale
    logic signed [15:0] r_s7_temp;
    logic signed [39:0] r_s7_off;
    logic signed [42:0] r_s7_q;
    logic signed [63:0] prod;

    assign prod = $signed({r_s6_ph[43:0], 20'h00000})
                + $signed({20'h00000, r_s6_pl});

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s7_temp <= r_s6_temp;
            r_s7_off  <= r_s6_off;
            r_s7_q    <= prod[63:21];
        end
    end

    // stage 8: pressure and clamp
    logic signed [15:0] r_s8_temp;
    logic        [17:0] r_s8_pres;
    logic signed [43:0] diff;
    logic signed [28:0] ps;
    logic        [17:0] n_s8_pres;

    always_comb begin
        diff = $signed({r_s7_q[42], r_s7_q})
             - $signed({{4{r_s7_off[39]}}, r_s7_off});
        ps   = diff[43:15];
        if (ps[28]) begin
            n_s8_pres = '0;
        end else if (|ps[27:18]) begin
            n_s8_pres = '1;
        end else begin
            n_s8_pres = ps[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r_s8_temp <= r_s7_temp;
            r_s8_pres <= n_s8_pres;
        end
    end

    assign o_res.valid                     = r_v[NST-1];
    assign o_res.payload.temperature_centi = r_s8_temp;
    assign o_res.payload.pressure_centi    = r_s8_pres;

    `BPT_ASSERT(a_ready_only_when_full, !i_req.ready |-> r_v[0], "input refused with room")
    `BPT_ASSERT(a_corr_zero_together, r_v[4] && r_s4_off2 == '0 |-> r_s4_sens2 == '0, "corrections disagree")
    `BPT_ASSERT(a_warm_no_t2, r_v[4] && r_s4_off2 == '0 |-> r_s4_temp >= 16'sd2000, "warm temperature corrected")
    `BPT_ASSERT_NR(a_rst_idle, !i_rst_n |=> !o_res.valid, "result valid after reset")

endmodule
